[rtl/ifs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_pkg
// Types and constants shared by the IFS field splitter modules.
// ----------------------------------------------------------------------------
package ifs_pkg;

    // input event kinds
    localparam logic [1:0] KIND_UNQUOTED = 2'd0;
    localparam logic [1:0] KIND_QUOTED   = 2'd1;
    localparam logic [1:0] KIND_EMPTY_Q  = 2'd2;
    localparam logic [1:0] KIND_SEG_END  = 2'd3;

    // result kinds
    localparam logic OUT_CHAR      = 1'b0;
    localparam logic OUT_FIELD_END = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_IFS_LENGTH = 3'd0;
    localparam logic [2:0] REG_IFS_CHAR_A = 3'd1;
    localparam logic [2:0] REG_IFS_CHAR_B = 3'd2;
    localparam logic [2:0] REG_IFS_CHAR_C = 3'd3;
    localparam logic [2:0] REG_IFS_CHAR_D = 3'd4;

    // reset values of the configuration registers
    localparam logic [2:0] IFS_LENGTH_RST = 3'd3;
    localparam logic [7:0] IFS_CHAR_A_RST = 8'd32;
    localparam logic [7:0] IFS_CHAR_B_RST = 8'd9;
    localparam logic [7:0] IFS_CHAR_C_RST = 8'd10;
    localparam logic [7:0] IFS_CHAR_D_RST = 8'd0;

    // characters that count as IFS whitespace
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // result queue: depth must be a power of two, at least 4
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_in;
    } in_word_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] char_out;
        logic       char_quoted;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [2:0] ifs_length;
        logic [7:0] ifs_char_a;
        logic [7:0] ifs_char_b;
        logic [7:0] ifs_char_c;
        logic [7:0] ifs_char_d;
    } ifs_cfg_t;

    // up to two results per input word, first one goes out first
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } split_res_t;

endpackage

[rtl/ifs_split_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_split_core
// Splitter state and per-word result decode.
// ----------------------------------------------------------------------------
module ifs_split_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ifs_pkg::in_word_t   in_data,
    input  ifs_pkg::ifs_cfg_t   cfg,
    output ifs_pkg::split_res_t res
);
    import ifs_pkg::*;

    logic leading_trim_reg, leading_trim_next;
    logic in_delim_reg, in_delim_next;
    logic saw_other_reg, saw_other_next;
    logic has_content_reg, has_content_next;

    logic       splitting;
    logic       ifs_hit;
    logic       is_other;
    logic       emit_end;
    logic       emit_char;
    logic [7:0] ch;
    out_word_t  end_word;
    out_word_t  char_word;

    assign ch        = in_data.char_in;
    assign splitting = (cfg.ifs_length != 3'd0);
    // lengths above four act as four
    assign ifs_hit   = ((cfg.ifs_length >= 3'd1) && (ch == cfg.ifs_char_a))
                    || ((cfg.ifs_length >= 3'd2) && (ch == cfg.ifs_char_b))
                    || ((cfg.ifs_length >= 3'd3) && (ch == cfg.ifs_char_c))
                    || ((cfg.ifs_length >= 3'd4) && (ch == cfg.ifs_char_d));
    assign is_other  = !((ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_NEWLINE));

    always_comb
    begin
        leading_trim_next = leading_trim_reg;
        in_delim_next     = in_delim_reg;
        saw_other_next    = saw_other_reg;
        has_content_next  = has_content_reg;
        emit_end          = 1'b0;
        emit_char         = 1'b0;

        unique case (in_data.kind) inside
            KIND_SEG_END:
            begin
                emit_end = has_content_reg
                        || (splitting && in_delim_reg && saw_other_reg);
                leading_trim_next = 1'b1;
                in_delim_next     = 1'b0;
                saw_other_next    = 1'b0;
                has_content_next  = 1'b0;
            end
            KIND_UNQUOTED, KIND_QUOTED, KIND_EMPTY_Q:
            begin
                if (!splitting)
                begin
                    leading_trim_next = 1'b0;
                    has_content_next  = 1'b1;
                    emit_char         = (in_data.kind != KIND_EMPTY_Q);
                end
                else if ((in_data.kind == KIND_UNQUOTED) && ifs_hit)
                begin
                    if (leading_trim_reg)
                    begin
                        if (is_other)
                        begin
                            leading_trim_next = 1'b0;
                            in_delim_next     = 1'b1;
                            saw_other_next    = 1'b1;
                        end
                    end
                    else if (!in_delim_reg)
                    begin
                        in_delim_next  = 1'b1;
                        saw_other_next = is_other;
                    end
                    else if (is_other)
                    begin
                        // second non-white separator: empty field between
                        if (saw_other_reg)
                        begin
                            emit_end         = 1'b1;
                            has_content_next = 1'b0;
                        end
                        else
                        begin
                            saw_other_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // text closes a pending delimiter first
                    emit_end          = in_delim_reg;
                    in_delim_next     = 1'b0;
                    saw_other_next    = 1'b0;
                    leading_trim_next = 1'b0;
                    has_content_next  = 1'b1;
                    emit_char         = (in_data.kind != KIND_EMPTY_Q);
                end
            end
            default:
            begin
                emit_end = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        end_word.out_kind     = OUT_FIELD_END;
        end_word.char_out     = 8'd0;
        end_word.char_quoted  = 1'b0;
        end_word.last         = !emit_char;
        char_word.out_kind    = OUT_CHAR;
        char_word.char_out    = ch;
        char_word.char_quoted = (in_data.kind == KIND_QUOTED);
        char_word.last        = 1'b1;

        res = '0;
        if (emit_end && emit_char)
        begin
            res.count  = 2'd2;
            res.first  = end_word;
            res.second = char_word;
        end
        else if (emit_end)
        begin
            res.count = 2'd1;
            res.first = end_word;
        end
        else if (emit_char)
        begin
            res.count = 2'd1;
            res.first = char_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leading_trim_reg <= 1'b1;
            in_delim_reg     <= 1'b0;
            saw_other_reg    <= 1'b0;
            has_content_reg  <= 1'b0;
        end
        else if (accept)
        begin
            leading_trim_reg <= leading_trim_next;
            in_delim_reg     <= in_delim_next;
            saw_other_reg    <= saw_other_next;
            has_content_reg  <= has_content_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_other_needs_delim: assert property (@(posedge clk) disable iff (!rst_n)
        saw_other_reg |-> in_delim_reg)
        else $error("separator flag set outside a delimiter");

    a_delim_not_trim: assert property (@(posedge clk) disable iff (!rst_n)
        in_delim_reg |-> !leading_trim_reg)
        else $error("delimiter open during leading trim");

    a_content_not_trim: assert property (@(posedge clk) disable iff (!rst_n)
        has_content_reg |-> !leading_trim_reg)
        else $error("field content during leading trim");

    a_seg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.kind == KIND_SEG_END)) |=>
            (leading_trim_reg && !in_delim_reg && !has_content_reg))
        else $error("segment end did not clear splitter state");
`endif

endmodule

[rtl/ifs_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_result_fifo
// Small result queue: takes up to two words per cycle, sends one while out_stall is low.
// ----------------------------------------------------------------------------
module ifs_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ifs_pkg::split_res_t res,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output ifs_pkg::out_word_t  out_data
);
    import ifs_pkg::*;

    out_word_t            mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]  count_reg, count_next;
    logic [1:0]           push_n;
    logic                 pop;
    logic [RQ_PTR_W-1:0]  wr_ptr_plus1;

    assign push_n       = push ? res.count : 2'd0;
    assign out_valid    = (count_reg != '0);
    assign pop          = out_valid && !out_stall;
    assign out_data     = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    // room for two words is needed before a new input word is taken
    assign full         = (count_reg > RQ_CNT_W'(RQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= res.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("word pushed into full result queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < RQ_CNT_W'(RQ_DEPTH)) |->
            (RQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) == RQ_PTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/ifs_field_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_field_splitter
// Streamed shell IFS field splitting of character events into characters
// and field-end markers.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_stall  | in_data  (kind, char_in)
//  out     | out | out_valid / out_stall| out_data (out_kind, char_out,
//          |     |                      |           char_quoted, last)
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One input word per cycle while in_stall is low; its zero, one or two
//  results land in a four-entry result queue the next cycle and leave one
//  per cycle while out_stall is low. Input stalls while the queue holds
//  more than two words, so a stream of two results per word is output-bound.
//  Reset restores the IFS registers to space, tab, newline (length 3).
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ifs_field_splitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ifs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ifs_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import ifs_pkg::*;

    ifs_cfg_t   cfg_reg;
    split_res_t res;
    logic       accept;
    logic       full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ifs_length <= IFS_LENGTH_RST;
            cfg_reg.ifs_char_a <= IFS_CHAR_A_RST;
            cfg_reg.ifs_char_b <= IFS_CHAR_B_RST;
            cfg_reg.ifs_char_c <= IFS_CHAR_C_RST;
            cfg_reg.ifs_char_d <= IFS_CHAR_D_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IFS_LENGTH: cfg_reg.ifs_length <= cfg_data[2:0];
                REG_IFS_CHAR_A: cfg_reg.ifs_char_a <= cfg_data;
                REG_IFS_CHAR_B: cfg_reg.ifs_char_b <= cfg_data;
                REG_IFS_CHAR_C: cfg_reg.ifs_char_c <= cfg_data;
                REG_IFS_CHAR_D: cfg_reg.ifs_char_d <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    ifs_split_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .cfg     (cfg_reg),
        .res     (res)
    );

    ifs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_end_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.out_kind == OUT_FIELD_END)) |->
            ((out_data.char_out == 8'd0) && !out_data.char_quoted))
        else $error("field end carries character data");

    a_quoted_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.char_quoted) |-> (out_data.out_kind == OUT_CHAR))
        else $error("quoted flag on a field end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IFS field splitter. Character events go in
// under random bursts and gaps while the output side stalls in changing
// patterns. Each accepted event is run through a bit-true prediction of
// the POSIX splitting rules. Every result word is checked against the oldest
// outstanding prediction. The IFS registers are reloaded between phases,
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import ifs_pkg::*;

    localparam int unsigned     CLK_HALF        = 4;
    localparam int unsigned     RESET_CYCLES    = 12;
    localparam int unsigned     RANDOM_PHASES   = 9;
    localparam int unsigned     WORDS_PER_PHASE = 100;
    localparam int unsigned     SETTLE_CYCLES   = 4;
    localparam int unsigned     DRAIN_CYCLES    = 20;
    localparam longint unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned     REPORT_MAX      = 10;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    class field_split_checker;
        ifs_cfg_t    regs;
        bit          trim;
        bit          in_delim;
        bit          delim_other;
        bit          has_content;
        out_word_t   pending_pieces[$];
        int unsigned bad_pieces;
        int unsigned piece_num;

        function new();
            regs = '{IFS_LENGTH_RST, IFS_CHAR_A_RST, IFS_CHAR_B_RST,
                     IFS_CHAR_C_RST, IFS_CHAR_D_RST};
            seg_clear();
            bad_pieces = 0;
            piece_num  = 0;
        endfunction

        function void seg_clear();
            trim        = 1'b1;
            in_delim    = 1'b0;
            delim_other = 1'b0;
            has_content = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] d);
            case (idx)
                REG_IFS_LENGTH: regs.ifs_length = d[2:0];
                REG_IFS_CHAR_A: regs.ifs_char_a = d;
                REG_IFS_CHAR_B: regs.ifs_char_b = d;
                REG_IFS_CHAR_C: regs.ifs_char_c = d;
                REG_IFS_CHAR_D: regs.ifs_char_d = d;
                default: ;
            endcase
        endfunction

        // lengths above four use all four characters
        function bit is_sep(logic [7:0] ch);
            int unsigned n;
            n = (regs.ifs_length > 3'd4) ? 4 : int'(regs.ifs_length);
            return (n > 0 && ch == regs.ifs_char_a) || (n > 1 && ch == regs.ifs_char_b) ||
                   (n > 2 && ch == regs.ifs_char_c) || (n > 3 && ch == regs.ifs_char_d);
        endfunction

        function out_word_t piece(logic k, logic [7:0] ch, logic q);
            out_word_t p;
            p.out_kind    = k;
            p.char_out    = ch;
            p.char_quoted = q;
            p.last        = 1'b0;
            return p;
        endfunction

        function void take_event(in_word_t w);
            out_word_t res[$];
            out_word_t tail;
            bit        splitting;
            bit        other;
            splitting = regs.ifs_length != 3'd0;
            if (w.kind == KIND_SEG_END) begin
                if (has_content || (splitting && in_delim && delim_other))
                    res = {res, piece(OUT_FIELD_END, 8'h00, 1'b0)};
                seg_clear();
            end
            else if (!splitting) begin
                trim        = 1'b0;
                has_content = 1'b1;
                if (w.kind != KIND_EMPTY_Q)
                    res = {res, piece(OUT_CHAR, w.char_in, w.kind == KIND_QUOTED)};
            end
            else if (w.kind == KIND_UNQUOTED && is_sep(w.char_in)) begin
                other = !(w.char_in == CHAR_SPACE || w.char_in == CHAR_TAB ||
                          w.char_in == CHAR_NEWLINE);
                if (trim) begin
                    // leading blanks vanish; a non-blank separator ends the trim
                    if (other) begin
                        trim        = 1'b0;
                        in_delim    = 1'b1;
                        delim_other = 1'b1;
                    end
                end
                else if (!in_delim) begin
                    in_delim    = 1'b1;
                    delim_other = other;
                end
                else if (other) begin
                    // second non-blank separator in one run: empty field between
                    if (delim_other) begin
                        res = {res, piece(OUT_FIELD_END, 8'h00, 1'b0)};
                        has_content = 1'b0;
                    end
                    else begin
                        delim_other = 1'b1;
                    end
                end
            end
            else begin
                if (in_delim) begin
                    res = {res, piece(OUT_FIELD_END, 8'h00, 1'b0)};
                    has_content = 1'b0;
                    in_delim    = 1'b0;
                    delim_other = 1'b0;
                end
                trim        = 1'b0;
                has_content = 1'b1;
                if (w.kind != KIND_EMPTY_Q)
                    res = {res, piece(OUT_CHAR, w.char_in, w.kind == KIND_QUOTED)};
            end
            if (res.size() > 0) begin
                tail                 = res[res.size() - 1];
                tail.last            = 1'b1;
                res[res.size() - 1]  = tail;
            end
            pending_pieces = {pending_pieces, res};
        endfunction

        function void report(string msg);
            bad_pieces++;
            if (bad_pieces <= REPORT_MAX)
                $display("ERROR result %0d: %s", piece_num, msg);
        endfunction

        function void check_piece(out_word_t got);
            out_word_t want;
            piece_num++;
            if (pending_pieces.size() == 0) begin
                report($sformatf("unexpected word kind=%0d char=%02h q=%0d last=%0d",
                                 got.out_kind, got.char_out, got.char_quoted, got.last));
                return;
            end
            want = pending_pieces.pop_front();
            if (got.out_kind !== want.out_kind || got.char_out !== want.char_out ||
                got.char_quoted !== want.char_quoted || got.last !== want.last)
                report({$sformatf("exp kind=%0d char=%02h q=%0d last=%0d",
                                  want.out_kind, want.char_out, want.char_quoted,
                                  want.last),
                        $sformatf(", got kind=%0d char=%02h q=%0d last=%0d",
                                  got.out_kind, got.char_out, got.char_quoted,
                                  got.last)});
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    field_split_checker chk;
    longint unsigned    cycles = 0;
    int unsigned        burst_left;
    int unsigned        gap_len;

    ifs_field_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            chk.check_piece(out_data);
    end

    // output back-pressure: the stall mode is redrawn at random intervals
    initial
    begin : stall_gen
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        out_stall <= 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (tick % 4 != 0);
            endcase
        end
    end

    function automatic in_word_t mk_word(logic [1:0] k, logic [7:0] c);
        in_word_t w;
        w.kind    = k;
        w.char_in = c;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        chk.take_event(w);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
    endtask

    // '$' is a segment end, '~' an empty quoted piece, all else unquoted
    task automatic send_str(input string s);
        in_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == "$")
                w = mk_word(KIND_SEG_END, 8'h00);
            else if (s[i] == "~")
                w = mk_word(KIND_EMPTY_Q, 8'h00);
            else
                w = mk_word(KIND_UNQUOTED, s[i]);
            send_word(w);
        end
    endtask

    // wait until every predicted word is out, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        while (chk.pending_pieces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        chk.write_reg(idx, d);
    endtask

    task automatic load_cfg(input ifs_cfg_t c);
        write_reg(REG_IFS_LENGTH, {5'd0, c.ifs_length});
        write_reg(REG_IFS_CHAR_A, c.ifs_char_a);
        write_reg(REG_IFS_CHAR_B, c.ifs_char_b);
        write_reg(REG_IFS_CHAR_C, c.ifs_char_c);
        write_reg(REG_IFS_CHAR_D, c.ifs_char_d);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 7))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_NEWLINE;
            3: return CHAR_COLON;
            4: return CHAR_COMMA;
            5: return 8'h00;
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic ifs_cfg_t phase_cfg(int unsigned p);
        case (p)
            0: return '{IFS_LENGTH_RST, IFS_CHAR_A_RST, IFS_CHAR_B_RST,
                        IFS_CHAR_C_RST, IFS_CHAR_D_RST};
            1: return '{3'd0, rand_sep(), rand_sep(), rand_sep(), rand_sep()};
            2: return '{3'd4, 8'h00, 8'hFF, CHAR_COLON, CHAR_SPACE};
            3: return '{3'd7, CHAR_COLON, CHAR_TAB, 8'hFF, CHAR_SPACE};
            4: return '{3'd5, rand_sep(), rand_sep(), rand_sep(), rand_sep()};
            default: return '{3'($urandom_range(1, 4)), rand_sep(), rand_sep(),
                              rand_sep(), rand_sep()};
        endcase
    endfunction

    // separators dominate so that delimiter runs get long
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1: return chk.regs.ifs_char_a;
            2: return chk.regs.ifs_char_b;
            3: return chk.regs.ifs_char_c;
            4: return chk.regs.ifs_char_d;
            5: return rand_sep();
            6, 7, 8: return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_word_t random_word();
        int unsigned r;
        logic [1:0]  k;
        r = $urandom_range(0, 99);
        if (r < 8)
            k = KIND_SEG_END;
        else if (r < 13)
            k = KIND_EMPTY_Q;
        else if (r < 25)
            k = KIND_QUOTED;
        else
            k = KIND_UNQUOTED;
        return mk_word(k, pick_char());
    endfunction

    initial
    begin
        chk = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        burst_left = 0;
        gap_len    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset IFS: leading trim, blank runs, quoted separators, empty pieces
        send_str(" \ta \n");
        send_word(mk_word(KIND_QUOTED, 8'hFF));
        send_word(mk_word(KIND_QUOTED, CHAR_SPACE));
        send_str("~ ~$$");
        send_word(mk_word(KIND_UNQUOTED, 8'h00));
        send_str(" $");

        // non-blank separator: lone ':', trailing '::', blank-wrapped ':'
        settle();
        load_cfg('{3'd4, CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_COLON});
        send_str(":$a::$ : b$");

        // splitting off
        settle();
        load_cfg('{3'd0, CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_COLON});
        send_str("x ~$$");

        // oversized length, byte extremes as separators
        settle();
        load_cfg('{3'd7, 8'h00, 8'hFF, CHAR_COLON, CHAR_SPACE});
        send_word(mk_word(KIND_UNQUOTED, 8'h00));
        send_str("q");
        send_word(mk_word(KIND_UNQUOTED, 8'hFF));
        send_word(mk_word(KIND_QUOTED, 8'h00));
        send_str("$");

        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            load_cfg(phase_cfg(p));
            repeat (WORDS_PER_PHASE) send_word(random_word());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.bad_pieces == 0 && chk.pending_pieces.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
